/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// ASSERT_CLK wraps a whole property; ASSERT_IMPL builds an overlapping implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons))
`endif

/* rtl/core/hct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_pkg
// Types and constants of the heat/cool thermostat core.
// ----------------------------------------------------------------------------
package hct_pkg;

    localparam int unsigned TEMP_W     = 12;
    localparam int unsigned HYST_W     = 10;
    localparam int unsigned MASK_W     = 2;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned FACTOR_W   = 9;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned THR_W      = 14;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 3;

    // Q8 factor applied to the hysteresis for the switch-off thresholds
    localparam logic [FACTOR_W-1:0] HYST_FACTOR_Q8 = 9'd128;

    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COOL = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_TARGET       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HYST_LOW     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HYST_HIGH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HEAT_MIN_ON  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HEAT_MIN_OFF = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COOL_MIN_ON  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COOL_MIN_OFF = 3'd7;

    typedef struct packed {
        logic signed [TEMP_W-1:0] set_point;
        logic [HYST_W-1:0]        hyst_low;
        logic [HYST_W-1:0]        hyst_high;
        logic [MASK_W-1:0]        enable_mask;
        logic [MS_W-1:0]          heat_min_on;
        logic [MS_W-1:0]          heat_min_off;
        logic [MS_W-1:0]          cool_min_on;
        logic [MS_W-1:0]          cool_min_off;
    } t_cfg;

    typedef struct packed {
        logic [MS_W-1:0]          now_ms;
        logic signed [TEMP_W-1:0] temperature;
        logic                     sensor_ok;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              heater_drive;
        logic              cooler_drive;
    } t_result;

endpackage
`default_nettype wire

/* rtl/core/hct_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_in_if
// Evaluation item channel: time stamp, temperature and sensor flag.
// ----------------------------------------------------------------------------
interface hct_in_if
    import hct_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MS_W-1:0]          now_ms;
    logic signed [TEMP_W-1:0] temperature;
    logic                     sensor_ok;

    modport source (output valid, output now_ms, output temperature, output sensor_ok,
                    input ready);
    modport sink   (input valid, input now_ms, input temperature, input sensor_ok,
                    output ready);
endinterface
`default_nettype wire

/* rtl/core/hct_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_out_if
// Result item channel: mode and the two drive outputs.
// ----------------------------------------------------------------------------
interface hct_out_if
    import hct_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              heater_drive;
    logic              cooler_drive;

    modport source (output valid, output mode, output heater_drive, output cooler_drive,
                    input ready);
    modport sink   (input valid, input mode, input heater_drive, input cooler_drive,
                    output ready);
endinterface
`default_nettype wire

/* rtl/core/hct_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_cfg
// APB register file holding the thermostat settings.
// ----------------------------------------------------------------------------
module hct_cfg
    import hct_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_point    <= 12'sd320;
            r_cfg.hyst_low     <= 10'd16;
            r_cfg.hyst_high    <= 10'd16;
            r_cfg.enable_mask  <= '0;
            r_cfg.heat_min_on  <= '0;
            r_cfg.heat_min_off <= '0;
            r_cfg.cool_min_on  <= '0;
            r_cfg.cool_min_off <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TARGET: begin
                    r_cfg.set_point <= $signed(pwdata[TEMP_W-1:0]);
                end
                REG_HYST_LOW: begin
                    r_cfg.hyst_low <= pwdata[HYST_W-1:0];
                end
                REG_HYST_HIGH: begin
                    r_cfg.hyst_high <= pwdata[HYST_W-1:0];
                end
                REG_ENABLE: begin
                    r_cfg.enable_mask <= pwdata[MASK_W-1:0];
                end
                REG_HEAT_MIN_ON: begin
                    r_cfg.heat_min_on <= pwdata[MS_W-1:0];
                end
                REG_HEAT_MIN_OFF: begin
                    r_cfg.heat_min_off <= pwdata[MS_W-1:0];
                end
                REG_COOL_MIN_ON: begin
                    r_cfg.cool_min_on <= pwdata[MS_W-1:0];
                end
                REG_COOL_MIN_OFF: begin
                    r_cfg.cool_min_off <= pwdata[MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TARGET:       prdata = CFG_DATA_W'(r_cfg.set_point);
            REG_HYST_LOW:     prdata = CFG_DATA_W'(r_cfg.hyst_low);
            REG_HYST_HIGH:    prdata = CFG_DATA_W'(r_cfg.hyst_high);
            REG_ENABLE:       prdata = CFG_DATA_W'(r_cfg.enable_mask);
            REG_HEAT_MIN_ON:  prdata = CFG_DATA_W'(r_cfg.heat_min_on);
            REG_HEAT_MIN_OFF: prdata = CFG_DATA_W'(r_cfg.heat_min_off);
            REG_COOL_MIN_ON:  prdata = CFG_DATA_W'(r_cfg.cool_min_on);
            REG_COOL_MIN_OFF: prdata = CFG_DATA_W'(r_cfg.cool_min_off);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/hct_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_eval
// Mode state, toggle times and the combinational switching decision.
// ----------------------------------------------------------------------------
module hct_eval
    import hct_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    logic [MODE_W-1:0] r_mode,     n_mode;
    logic [MS_W-1:0]   r_heat_tog, n_heat_tog;
    logic [MS_W-1:0]   r_cool_tog, n_cool_tog;

    logic [HYST_W+FACTOR_W-1:0] prod_lo, prod_hi;
    logic [HYST_W:0]            off_lo, off_hi;
    logic signed [THR_W-1:0]    temp_x, tgt_x;
    logic signed [THR_W-1:0]    heat_on, heat_off, cool_on, cool_off;
    logic [MS_W-1:0]            heat_age, cool_age;
    logic                       heat_en, cool_en, ok;

    // off offset = floor(hyst * factor / 256)
    assign prod_lo = i_cfg.hyst_low * HYST_FACTOR_Q8;
    assign prod_hi = i_cfg.hyst_high * HYST_FACTOR_Q8;
    assign off_lo  = prod_lo[HYST_W+FACTOR_W-1:FRAC_BITS];
    assign off_hi  = prod_hi[HYST_W+FACTOR_W-1:FRAC_BITS];

    assign temp_x   = THR_W'($signed(i_item.temperature));
    assign tgt_x    = THR_W'($signed(i_cfg.set_point));
    assign heat_on  = tgt_x - $signed(THR_W'(i_cfg.hyst_low));
    assign heat_off = tgt_x - $signed(THR_W'(off_lo));
    assign cool_on  = tgt_x + $signed(THR_W'(i_cfg.hyst_high));
    assign cool_off = tgt_x + $signed(THR_W'(off_hi));

    // wrapping elapsed time since each device last switched
    assign heat_age = i_item.now_ms - r_heat_tog;
    assign cool_age = i_item.now_ms - r_cool_tog;

    assign heat_en = i_cfg.enable_mask[0];
    assign cool_en = i_cfg.enable_mask[1];
    assign ok      = i_item.sensor_ok;

    always_comb begin
        n_mode     = r_mode;
        n_heat_tog = r_heat_tog;
        n_cool_tog = r_cool_tog;
        case (r_mode)
            MODE_HEAT: begin
                if ((!heat_en || !ok || temp_x >= heat_off) &&
                    heat_age >= i_cfg.heat_min_on) begin
                    n_mode     = MODE_IDLE;
                    n_heat_tog = i_item.now_ms;
                end
            end
            MODE_COOL: begin
                if ((!cool_en || !ok || temp_x <= cool_off) &&
                    cool_age >= i_cfg.cool_min_on) begin
                    n_mode     = MODE_IDLE;
                    n_cool_tog = i_item.now_ms;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (ok && heat_en && temp_x <= heat_on && heat_age >= i_cfg.heat_min_off) begin
                    n_mode     = MODE_HEAT;
                    n_heat_tog = i_item.now_ms;
                end
                // cooling start is checked last and wins
                if (ok && cool_en && temp_x >= cool_on && cool_age >= i_cfg.cool_min_off) begin
                    n_mode     = MODE_COOL;
                    n_cool_tog = i_item.now_ms;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_heat_tog <= '0;
            r_cool_tog <= '0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_heat_tog <= n_heat_tog;
            r_cool_tog <= n_cool_tog;
        end
    end

    assign o_result = {n_mode, (n_mode == MODE_HEAT), (n_mode == MODE_COOL)};

endmodule
`default_nettype wire

/* rtl/core/heat_cool_thermostat_core.sv */
// Heat/cool thermostat core.
// i_in carries one evaluation per item: now_ms (wrapping ms), temperature
// (signed, 1/16 C) and sensor_ok. o_out returns one item per evaluation:
// the mode after it (idle, heating, cooling) and the heater/cooler drives.
// Settings are written over the APB port (pready tied high), 8 registers at
// byte addresses 4*i; the user must write them only while no item is in
// flight; the block itself does not enforce this. An item taken into the
// input register moves to the result register once that is free or emptied.
// Throughput: one item per cycle unless o_out stalls; input register, one
// pass of compare logic with the mode/toggle-time update, result register.
// A stalled o_out holds its item; the input register still takes one more
// item, then i_in.ready drops until o_out is taken.
// Synchronous reset clears both valid flags, sets the mode to idle, both
// toggle times to zero and the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heat_cool_thermostat_core
// Top level: channel registers, settings and mode evaluation.
// ----------------------------------------------------------------------------
module heat_cool_thermostat_core
    import hct_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hct_in_if.sink                     i_in,
    hct_out_if.source                  o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg    cfg;
    t_item   r_item;
    t_result r_res, n_res;
    logic    r_in_vld, r_out_vld;
    logic    adv, fire, in_ready;

    hct_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hct_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (n_res)
    );

    // result register free or being emptied this cycle
    assign adv      = !r_out_vld || o_out.ready;
    assign in_ready = !r_in_vld || adv;
    assign fire     = r_in_vld && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_vld <= i_in.valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_item.now_ms      <= i_in.now_ms;
            r_item.temperature <= i_in.temperature;
            r_item.sensor_ok   <= i_in.sensor_ok;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_vld;
    assign o_out.mode         = r_res.mode;
    assign o_out.heater_drive = r_res.heater_drive;
    assign o_out.cooler_drive = r_res.cooler_drive;

endmodule
`default_nettype wire

/* rtl/core/hct_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hct_checker
// Port-level checks on the thermostat core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hct_checker
    import hct_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [MODE_W-1:0] i_out_mode,
    input wire logic              i_out_heater_drive,
    input wire logic              i_out_cooler_drive
);

    `ASSERT_IMPL(a_heat_drive, i_clk, i_rst_n, i_out_valid, i_out_heater_drive == (i_out_mode == MODE_HEAT))
    `ASSERT_IMPL(a_cool_drive, i_clk, i_rst_n, i_out_valid, i_out_cooler_drive == (i_out_mode == MODE_COOL))
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `ASSERT_IMPL(a_result_from_item, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2))
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mode))

endmodule

bind heat_cool_thermostat_core hct_checker u_hct_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_mode         (o_out.mode),
    .i_out_heater_drive (o_out.heater_drive),
    .i_out_cooler_drive (o_out.cooler_drive)
);
`default_nettype wire

/* tb/sv/heat_cool_thermostat_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_cool_thermostat_core_test
// Self-checking bench for the thermostat core. Settings go in over APB,
// evaluation items are pushed with random gaps and results are taken with
// random stalls; each result is checked against a mode tracker that follows
// the heating/cooling rules and minimum on/off times on its own.
// ----------------------------------------------------------------------------
module heat_cool_thermostat_core_test;
    import hct_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 125;
    localparam int PHASE_COUNT  = 6;

    class mode_tracker;
        t_cfg              settings;
        logic [MODE_W-1:0] mode;
        logic [MS_W-1:0]   heat_toggle_ms;
        logic [MS_W-1:0]   cool_toggle_ms;
        t_result           expected_modes[$];
        int                mismatches;
        int                idle_seen;
        int                heat_seen;
        int                cool_seen;

        function new();
            settings             = '0;
            settings.set_point   = 12'sd320;
            settings.hyst_low    = 10'd16;
            settings.hyst_high   = 10'd16;
            mode                 = MODE_IDLE;
            heat_toggle_ms       = '0;
            cool_toggle_ms       = '0;
            mismatches           = 0;
            idle_seen            = 0;
            heat_seen            = 0;
            cool_seen            = 0;
        endfunction

        // bits above each register's width are dropped
        function void write_setting(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_TARGET:       settings.set_point    = value[TEMP_W-1:0];
                REG_HYST_LOW:     settings.hyst_low     = value[HYST_W-1:0];
                REG_HYST_HIGH:    settings.hyst_high    = value[HYST_W-1:0];
                REG_ENABLE:       settings.enable_mask  = value[MASK_W-1:0];
                REG_HEAT_MIN_ON:  settings.heat_min_on  = value;
                REG_HEAT_MIN_OFF: settings.heat_min_off = value;
                REG_COOL_MIN_ON:  settings.cool_min_on  = value;
                REG_COOL_MIN_OFF: settings.cool_min_off = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_modes.size();
        endfunction

        // wrapping ms difference against a minimum
        function bit gate_open(logic [MS_W-1:0] now, logic [MS_W-1:0] last,
                               logic [MS_W-1:0] limit);
            logic [MS_W-1:0] elapsed;
            elapsed = now - last;
            return elapsed >= limit;
        endfunction

        function t_result next_outputs(t_item it);
            t_result r;
            int      temp;
            int      tgt;
            int      hl;
            int      hh;
            int      heat_on;
            int      heat_off;
            int      cool_on;
            int      cool_off;
            logic    heat_en;
            logic    cool_en;
            temp     = $signed(it.temperature);
            tgt      = $signed(settings.set_point);
            hl       = settings.hyst_low;
            hh       = settings.hyst_high;
            heat_en  = settings.enable_mask[0];
            cool_en  = settings.enable_mask[1];
            heat_on  = tgt - hl;
            heat_off = tgt - ((hl * int'(HYST_FACTOR_Q8)) >> FRAC_BITS);
            cool_on  = tgt + hh;
            cool_off = tgt + ((hh * int'(HYST_FACTOR_Q8)) >> FRAC_BITS);
            case (mode)
                MODE_HEAT: begin
                    if ((!heat_en || !it.sensor_ok || temp >= heat_off) &&
                        gate_open(it.now_ms, heat_toggle_ms, settings.heat_min_on)) begin
                        heat_toggle_ms = it.now_ms;
                        mode           = MODE_IDLE;
                    end
                end
                MODE_COOL: begin
                    if ((!cool_en || !it.sensor_ok || temp <= cool_off) &&
                        gate_open(it.now_ms, cool_toggle_ms, settings.cool_min_on)) begin
                        cool_toggle_ms = it.now_ms;
                        mode           = MODE_IDLE;
                    end
                end
                default: begin
                    mode = MODE_IDLE;
                    if (it.sensor_ok) begin
                        if (heat_en && temp <= heat_on &&
                            gate_open(it.now_ms, heat_toggle_ms, settings.heat_min_off)) begin
                            heat_toggle_ms = it.now_ms;
                            mode           = MODE_HEAT;
                        end
                        // cooling start is checked second and wins
                        if (cool_en && temp >= cool_on &&
                            gate_open(it.now_ms, cool_toggle_ms, settings.cool_min_off)) begin
                            cool_toggle_ms = it.now_ms;
                            mode           = MODE_COOL;
                        end
                    end
                end
            endcase
            r.mode         = mode;
            r.heater_drive = (mode == MODE_HEAT);
            r.cooler_drive = (mode == MODE_COOL);
            return r;
        endfunction

        function void note_evaluation(t_item it);
            expected_modes.push_back(next_outputs(it));
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_mode_item(t_result got);
            t_result want;
            if (expected_modes.size() == 0) begin
                report($sformatf("result with nothing expected, mode %0d", got.mode));
                return;
            end
            want = expected_modes.pop_front();
            if (got.mode !== want.mode)
                report($sformatf("mode %0d, expected %0d", got.mode, want.mode));
            if (got.heater_drive !== want.heater_drive)
                report($sformatf("heater_drive %b, expected %b",
                                 got.heater_drive, want.heater_drive));
            if (got.cooler_drive !== want.cooler_drive)
                report($sformatf("cooler_drive %b, expected %b",
                                 got.cooler_drive, want.cooler_drive));
            case (want.mode)
                MODE_HEAT: heat_seen++;
                MODE_COOL: cool_seen++;
                default:   idle_seen++;
            endcase
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    hct_in_if  in_ch ();
    hct_out_if out_ch ();

    heat_cool_thermostat_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mode_tracker     tracker = new();
    t_cfg            phase_cfg;
    logic [MS_W-1:0] clock_ms;
    int              items_sent     = 0;
    int              settings_count = 0;
    int              hold_request   = 0;
    int              quiet_cycles   = 0;
    bit              sender_no_gap  = 1'b0;
    bit              sink_no_stall  = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_cfg make_cfg(int target, int hl, int hh, int en,
                                      logic [MS_W-1:0] heat_on_ms, logic [MS_W-1:0] heat_off_ms,
                                      logic [MS_W-1:0] cool_on_ms, logic [MS_W-1:0] cool_off_ms);
        t_cfg c;
        c.set_point    = target[TEMP_W-1:0];
        c.hyst_low     = hl[HYST_W-1:0];
        c.hyst_high    = hh[HYST_W-1:0];
        c.enable_mask  = en[MASK_W-1:0];
        c.heat_min_on  = heat_on_ms;
        c.heat_min_off = heat_off_ms;
        c.cool_min_on  = cool_on_ms;
        c.cool_min_off = cool_off_ms;
        return c;
    endfunction

    function automatic t_item eval_of(logic [MS_W-1:0] now, int temp, bit ok);
        t_item it;
        it.now_ms      = now;
        it.temperature = temp[TEMP_W-1:0];
        it.sensor_ok   = ok;
        return it;
    endfunction

    function automatic t_cfg phase_settings(int p);
        t_cfg c;
        case (p)
            0: c = make_cfg(int'($urandom_range(0, 2880)) - 880, $urandom_range(0, 800),
                            $urandom_range(0, 800), 3, $urandom_range(0, 400),
                            $urandom_range(0, 400), $urandom_range(0, 400),
                            $urandom_range(0, 400));
            1: c = make_cfg(-880, 0, 800, 3, 0, 0, 0, 0);
            2: c = make_cfg(2000, 800, 0, 1, $urandom_range(0, 1000), $urandom_range(0, 1000),
                            $urandom_range(0, 1000), $urandom_range(0, 1000));
            // heater hardly ever leaves heating, cooling hardly ever starts
            3: c = make_cfg(int'($urandom_range(0, 2880)) - 880, $urandom_range(0, 40),
                            $urandom_range(0, 40), 3, 32'hFFFF_FFFF, $urandom_range(0, 300),
                            $urandom_range(0, 300), 32'hFFFF_FFFF);
            4: c = make_cfg(-2048, 1023, 1023, 3, 0, 0, 0, 0);
            default: c = make_cfg(int'($urandom_range(0, 2880)) - 880, $urandom_range(0, 800),
                                  $urandom_range(0, 800), 2, $urandom_range(0, 200),
                                  $urandom_range(0, 200), $urandom_range(0, 200),
                                  $urandom_range(0, 200));
        endcase
        return c;
    endfunction

    // mostly near the current thresholds, now and then anywhere in range
    task automatic build_evaluation(output t_item it);
        int tgt;
        int span;
        int t;
        tgt  = $signed(phase_cfg.set_point);
        span = (phase_cfg.hyst_low > phase_cfg.hyst_high) ? phase_cfg.hyst_low
                                                          : phase_cfg.hyst_high;
        span = span + 24;
        if ($urandom_range(0, 99) < 3)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 250);
        if ($urandom_range(0, 99) < 15)
            t = int'($urandom_range(0, 4095)) - 2048;
        else
            t = tgt + int'($urandom_range(0, 2 * span)) - span;
        if (t > 2047)
            t = 2047;
        if (t < -2048)
            t = -2048;
        it = eval_of(clock_ms, t, $urandom_range(0, 15) != 0);
    endtask

    // entered and left at a falling edge; psel stays up for a following write
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        tracker.write_setting(idx, value);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        logic [31:0] junk;
        junk = $urandom();
        write_register(REG_TARGET,       {junk[31:TEMP_W], c.set_point});
        write_register(REG_HYST_LOW,     {junk[31:HYST_W], c.hyst_low});
        write_register(REG_HYST_HIGH,    {junk[31:HYST_W], c.hyst_high});
        write_register(REG_ENABLE,       {junk[31:MASK_W], c.enable_mask});
        write_register(REG_HEAT_MIN_ON,  c.heat_min_on);
        write_register(REG_HEAT_MIN_OFF, c.heat_min_off);
        write_register(REG_COOL_MIN_ON,  c.cool_min_on);
        write_register(REG_COOL_MIN_OFF, c.cool_min_off);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        phase_cfg = c;
        settings_count++;
    endtask

    task automatic send_item(input t_item it);
        int gap;
        gap = sender_no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.now_ms      <= it.now_ms;
        in_ch.temperature <= it.temperature;
        in_ch.sensor_ok   <= it.sensor_ok;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        tracker.note_evaluation(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int    stall;
        t_result got;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1)
            @(negedge i_clk);
        forever begin
            stall = sink_no_stall ? 0 : $urandom_range(0, 7);
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1)
                @(posedge i_clk);
            got.mode         = out_ch.mode;
            got.heater_drive = out_ch.heater_drive;
            got.cooler_drive = out_ch.cooler_drive;
            tracker.check_mode_item(got);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_item it;
        int    p;
        int    n;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.now_ms      <= '0;
        in_ch.temperature <= '0;
        in_ch.sensor_ok   <= 1'b0;
        phase_cfg = make_cfg(320, 16, 16, 0, 0, 0, 0, 0);
        clock_ms  = $urandom();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: both devices disabled, field extremes
        send_item(eval_of(32'h0000_0000, -2048, 1'b1));
        send_item(eval_of(32'hFFFF_FFFF, 2047, 1'b0));
        send_item(eval_of(32'h5555_AAAA, 0, 1'b1));

        // heater off threshold 312, cooler on 352, all minimum times 100 ms
        drain_results();
        apply_settings(make_cfg(320, 16, 32, 3, 100, 100, 100, 100));
        send_item(eval_of(32'd1000, -2048, 1'b1));
        send_item(eval_of(32'd1050, 2047, 1'b1));   // held by heater minimum on
        send_item(eval_of(32'd1100, 2047, 1'b1));
        send_item(eval_of(32'd1150, 2047, 1'b1));
        send_item(eval_of(32'd1200, 0, 1'b0));      // held by cooler minimum on
        send_item(eval_of(32'd1250, 0, 1'b0));
        send_item(eval_of(32'd1255, -2048, 1'b0));  // sensor lost while idle
        send_item(eval_of(32'd1260, 2047, 1'b1));   // held by cooler minimum off
        send_item(eval_of(32'd1270, -2048, 1'b1));
        send_item(eval_of(32'd1280, 304, 1'b1));
        send_item(eval_of(32'd1380, 312, 1'b1));
        send_item(eval_of(32'hFFFF_FFF0, -2048, 1'b1));
        send_item(eval_of(32'h0000_0010, 2047, 1'b1)); // wrapped, only 32 ms
        send_item(eval_of(32'h0000_0060, 2047, 1'b1));

        // zero hysteresis: both starts pass at the target, cooling wins
        drain_results();
        apply_settings(make_cfg(0, 0, 0, 3, 0, 0, 0, 0));
        send_item(eval_of(32'd5, 0, 1'b1));
        send_item(eval_of(32'd6, 0, 1'b1));
        send_item(eval_of(32'd7, -1, 1'b1));
        send_item(eval_of(32'd8, 0, 1'b1));

        for (p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            apply_settings(phase_settings(p));
            sink_no_stall = (p == 4);
            // long result stall while items keep coming, so the input backs up
            if (p == 1)
                hold_request = 150;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                sender_no_gap = (p == 4) || (p == 1 && n < 40);
                if (p == 3 && n == 60)
                    drain_results();
                build_evaluation(it);
                send_item(it);
            end
        end

        drain_results();
        repeat (4) @(negedge i_clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        $display("Covered %0d evaluations over %0d register settings, with a long result",
                 items_sent, settings_count);
        $display("stall, drained pauses and wrapped timestamps: %0d idle, %0d heating, %0d cooling.",
                 tracker.idle_seen, tracker.heat_seen, tracker.cool_seen);
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* heat_cool_thermostat_core.f */
+incdir+rtl/core
rtl/core/hct_pkg.sv
rtl/core/hct_in_if.sv
rtl/core/hct_out_if.sv
rtl/core/hct_cfg.sv
rtl/core/hct_eval.sv
rtl/core/heat_cool_thermostat_core.sv
rtl/core/hct_checker.sv
tb/sv/heat_cool_thermostat_core_test.sv
